@@ rtl/core/tps_pkg.sv @@
// Shared types, constants and divide-by-constant helpers for the sequencer clock.
package tps_pkg;

  localparam int POS_W   = 17;
  localparam int PHASE_W = 33;
  localparam int INC_W   = 32;
  localparam int BEAT_W  = 10;
  localparam int CFG_W   = 32;

  // 96 ticks per beat = 3 << 5; the divide by 3 is done with a reciprocal
  localparam int BEAT_SHIFT       = 5;
  localparam int TICKS_PER_BEAT   = 3 << BEAT_SHIFT;
  localparam int BEAT_RECIP       = 2731;  // ceil(2^13 / 3), exact for 12-bit input
  localparam int BEAT_RECIP_SHIFT = 13;
  localparam int HALF_RECIP       = 43691; // ceil(2^17 / 3), exact for 15-bit input
  localparam int HALF_RECIP_SHIFT = 17;

  localparam logic [POS_W-1:0]   MAX_POSITION = 17'd95999;
  localparam logic [PHASE_W-1:0] PHASE_ONE    = 33'h1_0000_0000;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SONG_START  = 3'd0,
    REG_SONG_END    = 3'd1,
    REG_LOOP_START  = 3'd2,
    REG_LOOP_LENGTH = 3'd3,
    REG_PHASE_INC   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_RUN   = 3'd2,
    OP_BACK  = 3'd3,
    OP_NEXT  = 3'd4,
    OP_LOOP  = 3'd5,
    OP_SET   = 3'd6
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0] song_start;
    logic [POS_W-1:0] song_end;
    logic [POS_W-1:0] loop_start;
    logic [POS_W-1:0] loop_length;
    logic [INC_W-1:0] phase_inc;
  } cfg_t;

  // classified request from the front end
  typedef struct packed {
    op_t              op;
    logic             level;
    logic [POS_W-1:0] value;
  } cmd_t;

  // execute stage output, before the beat/half report is worked out
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [POS_W-1:0]   position;
    logic               pos_valid;
    logic               invalidate;
    logic               run_level;
    logic               run_changed;
    logic               loop_level;
    logic               loop_changed;
  } mid_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [POS_W-1:0]   position;
    logic               position_valid;
    logic               beat_valid;
    logic [BEAT_W-1:0]  beat_index;
    logic               half_level;
    logic               half_changed;
    logic               run_level;
    logic               run_changed;
    logic               loop_level;
    logic               loop_changed;
  } res_t;

  // pos / 96
  function automatic logic [10:0] beat_quot(input logic [POS_W-1:0] pos);
    logic [23:0] prod;
    prod = 24'(pos[POS_W-1:BEAT_SHIFT]) * 24'(BEAT_RECIP);
    return prod[23:BEAT_RECIP_SHIFT];
  endfunction

  // pos % 96 == 0, given q = pos / 96
  function automatic logic beat_hit(input logic [POS_W-1:0] pos, input logic [10:0] q);
    return (pos[BEAT_SHIFT-1:0] == '0) &&
           ((13'(q) * 13'd3) == 13'(pos[POS_W-1:BEAT_SHIFT]));
  endfunction

  // pos % 24 < 12, i.e. pos / 12 is even
  function automatic logic half_of(input logic [POS_W-1:0] pos);
    logic [30:0] prod;
    prod = 31'(pos[POS_W-1:2]) * 31'(HALF_RECIP);
    return ~prod[HALF_RECIP_SHIFT];
  endfunction

endpackage

@@ rtl/core/tps_queue.sv @@
// Small register-based FIFO used between the front end, execute and result sides.
module tps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/core/tps_front.sv @@
// Front end: accepts requests, decodes the command and queues it for execute.
module tps_front
  import tps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       command,
  input  logic [POS_W-1:0] value,
  input  logic             cmd_pop,
  output logic             cmd_valid,
  output cmd_t             cmd
);

  cmd_t decoded;
  logic keep;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_data;

  always_comb begin
    decoded.level = (value != '0);
    decoded.value = value;
    decoded.op    = OP_TICK;
    keep          = 1'b1;
    unique case (command)
      OP_TICK:  decoded.op = OP_TICK;
      OP_START: decoded.op = OP_START;
      OP_RUN:   decoded.op = OP_RUN;
      OP_BACK:  decoded.op = OP_BACK;
      OP_NEXT:  decoded.op = OP_NEXT;
      OP_LOOP:  decoded.op = OP_LOOP;
      OP_SET:   decoded.op = OP_SET;
      default:  keep = 1'b0;  // unused code: taken and dropped
    endcase
  end

  tps_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push && keep),
    .wr_data (decoded),
    .full    (full),
    .pop     (cmd_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = q_data;

endmodule

@@ rtl/core/tps_exec.sv @@
// Execute: owns position, phase, run/loop; one request per cycle unless stalled.
module tps_exec
  import tps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic mid_valid,
  output mid_t mid,
  input  logic mid_take
);

  logic [POS_W-1:0]   pos;
  logic [PHASE_W-1:0] phase;
  logic               running;
  logic               loop_mode;
  logic               resync;

  logic [POS_W-1:0]   pos_next;
  logic [PHASE_W-1:0] phase_next;
  logic               running_next;
  logic               loop_next;
  logic               resync_next;

  logic [10:0]        beat_q;
  logic [POS_W:0]     beat_floor;
  logic [POS_W-1:0]   loop_len;
  logic [POS_W:0]     loop_end;
  logic [POS_W-1:0]   base_pos;
  logic [PHASE_W-1:0] base_phase;
  logic [PHASE_W:0]   phase_sum;
  logic               phase_over;
  logic [POS_W:0]     target;
  logic [POS_W-1:0]   clipped;
  logic               settle;
  logic               emit;
  logic               run_evt;
  logic               loop_evt;
  logic               inval;
  logic               fire;

  assign fire    = cmd_valid && (!mid_valid || mid_take);
  assign cmd_pop = fire;

  always_comb begin
    beat_q     = beat_quot(pos);
    beat_floor = (POS_W+1)'(beat_q) * (POS_W+1)'(TICKS_PER_BEAT);
    loop_len   = (cfg.loop_length == '0) ? POS_W'(1) : cfg.loop_length;
    loop_end   = {1'b0, cfg.loop_start} + {1'b0, loop_len};
    base_pos   = resync ? pos - POS_W'(1) : pos;
    base_phase = resync ? PHASE_ONE : phase;
    phase_sum  = {1'b0, base_phase} + (PHASE_W+1)'(cfg.phase_inc);
    phase_over = phase_sum > {1'b0, PHASE_ONE};

    pos_next     = pos;
    phase_next   = phase;
    running_next = running;
    loop_next    = loop_mode;
    resync_next  = resync;
    target       = {1'b0, pos};
    settle       = 1'b0;
    emit         = 1'b0;
    run_evt      = 1'b0;
    loop_evt     = 1'b0;
    inval        = 1'b0;

    unique case (cmd.op)
      OP_TICK: begin
        if (running) begin
          resync_next = 1'b0;
          if (phase_over) begin
            phase_next = PHASE_W'(phase_sum - {1'b0, PHASE_ONE});
            target     = {1'b0, base_pos + POS_W'(1)};
            emit       = 1'b1;
          end else begin
            phase_next = phase_sum[PHASE_W-1:0];
            pos_next   = base_pos;
          end
        end
      end
      OP_START: begin
        inval  = 1'b1;
        target = {1'b0, loop_mode ? cfg.loop_start : cfg.song_start};
        settle = 1'b1;
      end
      OP_RUN: begin
        running_next = cmd.level;
        if (cmd.level) begin
          resync_next = 1'b1;
        end
        run_evt = 1'b1;
      end
      OP_BACK: begin
        inval  = 1'b1;
        target = (beat_q == '0) ? '0 : beat_floor - (POS_W+1)'(TICKS_PER_BEAT);
        settle = 1'b1;
      end
      OP_NEXT: begin
        inval  = 1'b1;
        target = beat_floor + (POS_W+1)'(TICKS_PER_BEAT);
        if (target > {1'b0, MAX_POSITION}) begin
          target = {1'b0, MAX_POSITION};
        end
        settle = 1'b1;
      end
      OP_LOOP: begin
        inval     = 1'b1;
        loop_next = cmd.level;
        loop_evt  = 1'b1;
        if (cmd.level) begin
          target = {1'b0, cfg.loop_start};
        end
        settle = 1'b1;
      end
      OP_SET: begin
        inval  = 1'b1;
        target = {1'b0, cmd.value};
        settle = 1'b1;
      end
      default: ;
    endcase

    // running: defer the report to the next sample; stopped: report now
    if (settle) begin
      if (running) begin
        resync_next = 1'b1;
        pos_next    = target[POS_W-1:0];
      end else begin
        emit = 1'b1;
      end
    end

    clipped = (target > {1'b0, MAX_POSITION}) ? MAX_POSITION : target[POS_W-1:0];
    if (emit) begin
      if (loop_next) begin
        pos_next = ({1'b0, clipped} >= loop_end) ? cfg.loop_start : clipped;
      end else if (clipped >= cfg.song_end) begin
        pos_next     = cfg.song_start;
        running_next = 1'b0;
        run_evt      = 1'b1;
      end else begin
        pos_next = clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= PHASE_ONE;
      running   <= 1'b0;
      loop_mode <= 1'b0;
      resync    <= 1'b0;
      mid_valid <= 1'b0;
    end else begin
      if (fire) begin
        pos       <= pos_next;
        phase     <= phase_next;
        running   <= running_next;
        loop_mode <= loop_next;
        resync    <= resync_next;
        mid_valid <= 1'b1;
      end else if (mid_take) begin
        mid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mid.phase        <= phase_next;
      mid.position     <= pos_next;
      mid.pos_valid    <= emit;
      mid.invalidate   <= inval;
      mid.run_level    <= running_next;
      mid.run_changed  <= run_evt;
      mid.loop_level   <= loop_next;
      mid.loop_changed <= loop_evt;
    end
  end

endmodule

@@ rtl/core/tps_report.sv @@
// Report stage: beat index, beat flag and half-beat level with change tracking.
module tps_report
  import tps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic mid_valid,
  input  mid_t mid,
  output logic mid_take,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  logic        last_known;
  logic        last_level;
  logic [10:0] quot;
  logic        half;
  logic        known_eff;

  assign mid_take = mid_valid && !res_full;
  assign res_push = mid_take;

  always_comb begin
    quot      = beat_quot(mid.position);
    half      = half_of(mid.position);
    known_eff = last_known && !mid.invalidate;

    res.phase        = mid.phase;
    res.run_level    = mid.run_level;
    res.run_changed  = mid.run_changed;
    res.loop_level   = mid.loop_level;
    res.loop_changed = mid.loop_changed;
    if (mid.pos_valid) begin
      res.position       = mid.position;
      res.position_valid = 1'b1;
      res.beat_valid     = beat_hit(mid.position, quot);
      res.beat_index     = quot[BEAT_W-1:0];
      res.half_level     = half;
      res.half_changed   = !known_eff || (half != last_level);
    end else begin
      res.position       = '0;
      res.position_valid = 1'b0;
      res.beat_valid     = 1'b0;
      res.beat_index     = '0;
      res.half_level     = 1'b0;
      res.half_changed   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_known <= 1'b0;
      last_level <= 1'b0;
    end else if (mid_take) begin
      if (mid.pos_valid) begin
        last_known <= 1'b1;
        last_level <= half;
      end else if (mid.invalidate) begin
        last_known <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tick_position_sequencer_clock.sv @@
// Top level of the 96-tick-per-beat sequencer clock.
//
// Sequencer clock at 96 ticks per beat. Requests enter through a queue-style
// port (push/full) and results leave through another (pop/empty); every
// command except the unused code 7 gives exactly one result, in order.
// A sample-tick request adds phase_increment (0.32 fraction of a tick) to a
// 1.32 phase while running; when the phase passes 1.0 the position steps by
// one, is clipped to 95999, and wraps to loop_start (loop mode) or to
// song_start with the clock stopped (song mode at song_end). Start, back,
// next, loop and set-position requests move the position; while running they
// arm a resync: the next sample restarts the phase at 1.0, reporting if inc > 0.
// Each reported position carries beat number, beat flag and half-beat level
// with a change flag. Throughput is one request per clock while the result
// side keeps up: the execute stage updates position, phase and run/loop state
// as it accepts each request, and that loop sets the rate. An accepted request
// lands in the command queue, then in the execute register, and its beat/half
// report is then written into the result queue, where it shows on the ports.
// Both sides stall independently; full only rises when the command queue
// backs up behind a stalled result side. Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect at once and are meant to be made while
// the clock is idle: index 0 song_start, 1 song_end, 2 loop_start,
// 3 loop_length, 4 phase_increment. Start positions above 95999 saturate;
// a loop length of zero acts as one.
module tick_position_sequencer_clock
  import tps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request side
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           command,
  input  logic [POS_W-1:0]     value,
  // result side
  input  logic                 pop,
  output logic                 empty,
  output logic [PHASE_W-1:0]   phase,
  output logic [POS_W-1:0]     position,
  output logic                 position_valid,
  output logic                 beat_valid,
  output logic [BEAT_W-1:0]    beat_index,
  output logic                 half_level,
  output logic                 half_changed,
  output logic                 run_level,
  output logic                 run_changed,
  output logic                 loop_level,
  output logic                 loop_changed,
  // configuration
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic [POS_W-1:0] cfg_pos;
  logic [POS_W-1:0] cfg_pos_sat;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  logic mid_valid;
  logic mid_take;
  mid_t mid;

  logic res_push;
  logic res_full;
  res_t res_in;
  logic [$bits(res_t)-1:0] res_data;
  res_t res_out;

  // ---- configuration registers ----
  assign cfg_pos     = cfg_data[POS_W-1:0];
  assign cfg_pos_sat = (cfg_pos > MAX_POSITION) ? MAX_POSITION : cfg_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.song_start  <= '0;
      cfg.song_end    <= POS_W'(TICKS_PER_BEAT);
      cfg.loop_start  <= '0;
      cfg.loop_length <= POS_W'(TICKS_PER_BEAT);
      cfg.phase_inc   <= 32'd973915;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SONG_START:  cfg.song_start  <= cfg_pos_sat;
        REG_SONG_END:    cfg.song_end    <= cfg_pos;
        REG_LOOP_START:  cfg.loop_start  <= cfg_pos_sat;
        REG_LOOP_LENGTH: cfg.loop_length <= cfg_pos;
        REG_PHASE_INC:   cfg.phase_inc   <= cfg_data[INC_W-1:0];
        default: ;  // writes past the register list are ignored
      endcase
    end
  end

  // ---- front end: accept and decode, queue to execute ----
  tps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .value     (value),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // The execute stage holds the clock state and takes one request per cycle unless the report side stalls.
  tps_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_take  (mid_take)
  );

  // ---- report: beat and half-beat fields ----
  tps_report u_report (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_take  (mid_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // ---- result queue: decouples the consumer from the pipeline ----
  tps_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_data)
  );

  assign res_out        = res_data;
  assign phase          = res_out.phase;
  assign position       = res_out.position;
  assign position_valid = res_out.position_valid;
  assign beat_valid     = res_out.beat_valid;
  assign beat_index     = res_out.beat_index;
  assign half_level     = res_out.half_level;
  assign half_changed   = res_out.half_changed;
  assign run_level      = res_out.run_level;
  assign run_changed    = res_out.run_changed;
  assign loop_level     = res_out.loop_level;
  assign loop_changed   = res_out.loop_changed;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the 96-tick-per-beat sequencer clock.
`timescale 1ns / 1ps

module testbench;
  import tps_pkg::*;

  // Code 7 is outside the op enum; the block drops it without a result.
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam logic [1:0]  HALF_UNKNOWN = 2'd2;
  localparam int unsigned POS_MASK     = 32'h1FFFF;
  localparam int unsigned HALF_PERIOD  = 24;
  localparam int unsigned HALF_SPLIT   = 12;
  // Three-stage pipe plus margin, used for the pause before register writes.
  localparam int          DRAIN_SLACK  = 8;
  localparam int          DRAIN_CAP    = 20000;

  // Clock, reset and every block input, known from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [2:0] command = '0;
  logic [POS_W-1:0] value = '0;
  logic pop = 1'b0;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic full;
  logic empty;
  logic [PHASE_W-1:0] phase;
  logic [POS_W-1:0] position;
  logic position_valid;
  logic beat_valid;
  logic [BEAT_W-1:0] beat_index;
  logic half_level;
  logic half_changed;
  logic run_level;
  logic run_changed;
  logic loop_level;
  logic loop_changed;

  tick_position_sequencer_clock DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .value          (value),
    .pop            (pop),
    .empty          (empty),
    .phase          (phase),
    .position       (position),
    .position_valid (position_valid),
    .beat_valid     (beat_valid),
    .beat_index     (beat_index),
    .half_level     (half_level),
    .half_changed   (half_changed),
    .run_level      (run_level),
    .run_changed    (run_changed),
    .loop_level     (loop_level),
    .loop_changed   (loop_changed),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Clock predictor: its own copy of the registers and the sequencer state.
  // ---------------------------------------------------------------------------
  int unsigned cfg_song_start;
  int unsigned cfg_song_end;
  int unsigned cfg_loop_start;
  int unsigned cfg_loop_length;
  logic [INC_W-1:0] cfg_phase_inc;

  int unsigned cur_pos;
  logic [PHASE_W:0] cur_phase;     // one spare bit for the add before the wrap test
  bit is_running;
  bit in_loop;
  bit resync_armed;
  logic [1:0] prev_half;

  // Results still owed by the block, oldest first.
  res_t expected_reports[$];

  // Run statistics and failure count.
  int requests_sent;
  int ignored_requests;
  int results_checked;
  int position_reports;
  int song_stops;
  int loop_wraps;
  int resyncs;
  int failures;

  // Idle percentages of the current phase.
  int send_idle_pct;
  int pop_stall_pct;

  function automatic void reset_predictor();
    cfg_song_start  = 0;
    cfg_song_end    = 96;
    cfg_loop_start  = 0;
    cfg_loop_length = 96;
    cfg_phase_inc   = 32'd973915;
    cur_pos         = 0;
    cur_phase       = {1'b0, PHASE_ONE};
    is_running      = 1'b0;
    in_loop         = 1'b0;
    resync_armed    = 1'b0;
    prev_half       = HALF_UNKNOWN;
  endfunction

  function automatic int unsigned clip_pos(int unsigned p);
    return (p > MAX_POSITION) ? int'(MAX_POSITION) : p;
  endfunction

  // Clip, wrap (loop or song end), then fill in the position report.
  function automatic void report_position(inout res_t r);
    int unsigned len;
    logic half;
    len = (cfg_loop_length == 0) ? 1 : cfg_loop_length;
    cur_pos = clip_pos(cur_pos);
    if (in_loop) begin
      if (cur_pos >= cfg_loop_start + len) begin
        cur_pos = cfg_loop_start;
        loop_wraps++;
      end
    end else if (cur_pos >= cfg_song_end) begin
      // song end rewinds and stops the clock, which counts as a run event
      cur_pos = cfg_song_start;
      is_running = 1'b0;
      r.run_changed = 1'b1;
      song_stops++;
    end
    half = (cur_pos % HALF_PERIOD) < HALF_SPLIT;
    r.position       = POS_W'(cur_pos);
    r.position_valid = 1'b1;
    r.beat_valid     = (cur_pos % TICKS_PER_BEAT) == 0;
    r.beat_index     = BEAT_W'(cur_pos / TICKS_PER_BEAT);
    r.half_level     = half;
    r.half_changed   = {1'b0, half} != prev_half;
    prev_half        = {1'b0, half};
    position_reports++;
  endfunction

  // Position moved by a command: report now if stopped, else resync on next tick.
  function automatic void settle(inout res_t r);
    if (is_running) begin
      resync_armed = 1'b1;
    end else begin
      report_position(r);
    end
  endfunction

  // Applies one request to the predicted state; has_result is 0 for code 7.
  function automatic void step_clock(input logic [2:0] cmd, input logic [POS_W-1:0] val,
                                     output res_t r, output bit has_result);
    int unsigned q;
    r = '0;
    has_result = 1'b1;
    case (cmd)
      OP_TICK: begin
        if (is_running) begin
          if (resync_armed) begin
            cur_pos = (cur_pos - 1) & POS_MASK;
            cur_phase = {1'b0, PHASE_ONE};
            resync_armed = 1'b0;
            resyncs++;
          end
          cur_phase = cur_phase + cfg_phase_inc;
          if (cur_phase > {1'b0, PHASE_ONE}) begin
            cur_phase = cur_phase - {1'b0, PHASE_ONE};
            cur_pos = (cur_pos + 1) & POS_MASK;
            report_position(r);
          end
        end
      end
      OP_START: begin
        prev_half = HALF_UNKNOWN;
        cur_pos = in_loop ? cfg_loop_start : cfg_song_start;
        settle(r);
      end
      OP_RUN: begin
        is_running = (val != 0);
        if (is_running) resync_armed = 1'b1;
        r.run_changed = 1'b1;
      end
      OP_BACK: begin
        prev_half = HALF_UNKNOWN;
        q = cur_pos / TICKS_PER_BEAT;
        cur_pos = (q == 0) ? 0 : (q - 1) * TICKS_PER_BEAT;
        settle(r);
      end
      OP_NEXT: begin
        prev_half = HALF_UNKNOWN;
        q = cur_pos / TICKS_PER_BEAT;
        cur_pos = clip_pos((q + 1) * TICKS_PER_BEAT);
        settle(r);
      end
      OP_LOOP: begin
        prev_half = HALF_UNKNOWN;
        in_loop = (val != 0);
        r.loop_changed = 1'b1;
        if (in_loop) cur_pos = cfg_loop_start;
        settle(r);
      end
      OP_SET: begin
        prev_half = HALF_UNKNOWN;
        cur_pos = val;
        settle(r);
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
    r.phase      = cur_phase[PHASE_W-1:0];
    r.run_level  = is_running;
    r.loop_level = in_loop;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic log_failure(string msg);
    failures++;
    if (failures <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic field_mismatch(string name, logic [PHASE_W-1:0] got,
                                logic [PHASE_W-1:0] want);
    log_failure($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                          results_checked, name, got, want));
  endtask

  // Receiver: pop changes at the falling edge, stalls per the current phase.
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Each popped result is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        log_failure($sformatf("result with no request pending (position %0d)", position));
      end else begin
        want = expected_reports.pop_front();
        results_checked++;
        if (phase !== want.phase) field_mismatch("phase", phase, want.phase);
        if (position !== want.position)
          field_mismatch("position", position, want.position);
        if (position_valid !== want.position_valid)
          field_mismatch("position_valid", position_valid, want.position_valid);
        if (beat_valid !== want.beat_valid)
          field_mismatch("beat_valid", beat_valid, want.beat_valid);
        if (beat_index !== want.beat_index)
          field_mismatch("beat_index", beat_index, want.beat_index);
        if (half_level !== want.half_level)
          field_mismatch("half_level", half_level, want.half_level);
        if (half_changed !== want.half_changed)
          field_mismatch("half_changed", half_changed, want.half_changed);
        if (run_level !== want.run_level)
          field_mismatch("run_level", run_level, want.run_level);
        if (run_changed !== want.run_changed)
          field_mismatch("run_changed", run_changed, want.run_changed);
        if (loop_level !== want.loop_level)
          field_mismatch("loop_level", loop_level, want.loop_level);
        if (loop_changed !== want.loop_changed)
          field_mismatch("loop_changed", loop_changed, want.loop_changed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_idle_pct = 56; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 56; end
      default: begin send_idle_pct = 30; pop_stall_pct = 30; end
    endcase
  endtask

  // Sends one request; push stays high after acceptance so back-to-back
  // requests need no gap. The next call or wait_drain decides its level.
  task automatic send_req(logic [2:0] cmd, logic [POS_W-1:0] val);
    res_t r;
    bit has_result;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    command <= cmd;
    value   <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    requests_sent++;
    step_clock(cmd, val, r, has_result);
    if (has_result) expected_reports.push_back(r);
    else ignored_requests++;
  endtask

  // Stop sending, let every owed result come out, then allow for a
  // dropped code-7 request still in the pipe.
  task automatic wait_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    push <= 1'b0;
    while (expected_reports.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes all five registers; only called with the block idle.
  task automatic set_config(logic [CFG_W-1:0] song_start, logic [CFG_W-1:0] song_end,
                            logic [CFG_W-1:0] loop_start, logic [CFG_W-1:0] loop_length,
                            logic [CFG_W-1:0] phase_inc);
    logic [CFG_W-1:0] data [5];
    reg_idx_t idx [5];
    data = '{song_start, song_end, loop_start, loop_length, phase_inc};
    idx  = '{REG_SONG_START, REG_SONG_END, REG_LOOP_START, REG_LOOP_LENGTH, REG_PHASE_INC};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    // start registers saturate, song end and loop length take the low 17 bits as they are
    cfg_song_start  = clip_pos(song_start & POS_MASK);
    cfg_song_end    = song_end & POS_MASK;
    cfg_loop_start  = clip_pos(loop_start & POS_MASK);
    cfg_loop_length = loop_length & POS_MASK;
    cfg_phase_inc   = phase_inc;
  endtask

  // Set-position values: half near the wrap points, the rest anywhere in 17 bits or up to 95999.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(3))
      0: return POS_W'($urandom_range(0, 131071));
      1: return POS_W'(cfg_song_end - $urandom_range(0, 20));
      2: return POS_W'(cfg_loop_start + cfg_loop_length - $urandom_range(0, 20));
      default: return POS_W'($urandom_range(0, 95999));
    endcase
  endfunction

  // Random traffic, mostly sample ticks so the running clock goes deep.
  // The four quarters cycle through the idling phases; halfway the sender
  // holds off until the block has caught up.
  task automatic run_random(int count, int loop_on_pct);
    int pick;
    int quarter;
    logic [2:0] cmd;
    logic [POS_W-1:0] val;
    quarter = -1;
    for (int i = 0; i < count; i++) begin
      if (i * 4 / count != quarter) begin
        quarter = i * 4 / count;
        if (quarter == 2) wait_drain();
        set_idling(quarter);
      end
      pick = $urandom_range(99);
      val  = POS_W'($urandom_range(0, 131071));
      if (pick < 55) begin
        cmd = OP_TICK;
      end else if (pick < 65) begin
        cmd = OP_RUN;
        if ($urandom_range(3) == 0) val = '0;
        else if (val == 0) val = 1;
      end else if (pick < 70) begin
        cmd = OP_START;
      end else if (pick < 76) begin
        cmd = OP_BACK;
      end else if (pick < 82) begin
        cmd = OP_NEXT;
      end else if (pick < 88) begin
        cmd = OP_LOOP;
        if ($urandom_range(99) >= loop_on_pct) val = '0;
        else if (val == 0) val = 1;
      end else if (pick < 97) begin
        cmd = OP_SET;
        val = pick_position();
      end else begin
        cmd = OP_UNUSED;
      end
      send_req(cmd, val);
    end
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset-value registers: stopped tick, ignored code, set extremes, back
  // below one beat, next at the top, loop on/off, start, run with resync.
  task automatic test_directed();
    set_idling(0);
    send_req(OP_TICK, 17'd0);          // stopped: phase holds, nothing reported
    send_req(OP_UNUSED, 17'h1FFFF);    // dropped
    send_req(OP_SET, 17'h1FFFF);       // clips to max, then song end rewinds
    send_req(OP_SET, 17'd95);
    send_req(OP_BACK, 17'd0);          // below one beat saturates at zero
    send_req(OP_SET, 17'd95999);
    send_req(OP_NEXT, 17'd0);          // reaches song end, rewinds to song start
    send_req(OP_LOOP, 17'd1);
    send_req(OP_NEXT, 17'd0);          // reaches loop end, back to loop start
    send_req(OP_SET, 17'd95999);
    send_req(OP_LOOP, 17'd0);
    send_req(OP_START, 17'd0);
    send_req(OP_RUN, 17'h10000);
    send_req(OP_TICK, 17'd0);          // resync from zero wraps down then back up
    send_req(OP_TICK, 17'd0);
    send_req(OP_NEXT, 17'd0);          // running: arms a resync
    send_req(OP_TICK, 17'd0);
    send_req(OP_SET, 17'd11);
    send_req(OP_TICK, 17'd0);
    send_req(OP_RUN, 17'd0);
    send_req(OP_TICK, 17'd0);
    wait_drain();
  endtask

  // Fast clock in song mode: frequent song-end stops and restarts.
  task automatic test_song_mode();
    set_config(32'd100, 32'd400, 32'd200, 32'd30, 32'hFFFF_FFFF);
    send_req(OP_RUN, 17'd1);
    run_random(150, 15);
  endtask

  // Half-rate clock with a short loop, loop mode mostly on.
  task automatic test_loop_mode();
    set_config(32'd0, 32'd95999, 32'd1000, 32'd50, 32'h8000_0000);
    send_req(OP_LOOP, 17'd1);
    send_req(OP_RUN, 17'd1);
    run_random(150, 85);
  endtask

  // Zero increment: a resync leaves the decremented position unreported.
  task automatic test_zero_increment();
    set_config(32'd5, 32'd500, 32'd0, 32'd96, 32'd0);
    set_idling(0);
    send_req(OP_SET, 17'd0);
    send_req(OP_RUN, 17'd1);
    send_req(OP_TICK, 17'd0);
    send_req(OP_TICK, 17'd0);
    send_req(OP_BACK, 17'd0);
    send_req(OP_TICK, 17'd0);
    run_random(60, 50);
  endtask

  // Register extremes: saturating starts, zero song end, zero loop length,
  // then a loop whose end lies past the top position.
  task automatic test_register_extremes();
    set_config(32'hFFFF_FFFF, 32'd0, 32'h0001_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_req(OP_RUN, 17'd1);
    run_random(100, 50);
    set_config(32'd0, 32'd95999, 32'd95900, 32'd95999, 32'hF000_0000);
    send_req(OP_RUN, 17'd1);
    run_random(100, 60);
  endtask

  // Several random settings with fast enough increments to move.
  task automatic test_random_settings();
    logic [CFG_W-1:0] inc;
    for (int round = 0; round < 4; round++) begin
      inc = $urandom();
      if ($urandom_range(3) != 0) inc[31:30] = 2'b11;
      set_config($urandom_range(0, 95999), $urandom_range(0, 2000),
                 $urandom_range(0, 95999), $urandom_range(1, 300), inc);
      send_req(OP_RUN, 17'd1);
      run_random(60, 50);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    set_idling(0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_song_mode();
    test_loop_mode();
    test_zero_increment();
    test_register_extremes();
    test_random_settings();

    wait_drain();
    if (expected_reports.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_reports.size()));

    $display("Covered %0d requests (%0d dropped), %0d results checked, %0d position reports",
             requests_sent, ignored_requests, results_checked, position_reports);
    $display("Song-end stops %0d, loop wraps %0d, resyncs %0d, mismatches %0d",
             song_stops, loop_wraps, resyncs, failures);
    if (failures == 0) begin
      $display("[tick_position_sequencer_clock] OK");
    end else begin
      $display("[tick_position_sequencer_clock] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still owed", expected_reports.size());
    $display("[tick_position_sequencer_clock] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tps_pkg.sv
rtl/core/tps_queue.sv
rtl/core/tps_front.sv
rtl/core/tps_exec.sv
rtl/core/tps_report.sv
rtl/core/tick_position_sequencer_clock.sv
verif/testbench.sv
